// ----- sv/ntpcal_pkg.sv -----
// ----------------------------------------------------------------------------
// ntpcal_pkg
// Shared types and constants of the NTP timestamp to local calendar converter.
// ----------------------------------------------------------------------------
package ntpcal_pkg;

  // pipeline shape
  localparam int LaneStages = 6;
  localparam int PipeStages = LaneStages + 2;

  // configuration register indexes
  localparam logic [0:0] CfgUtcOffset = 1'b0;
  localparam logic [0:0] CfgDstEnable = 1'b1;

  // 2^32 - 2208988800: moves the 1900 epoch to 1970 modulo 2^32
  localparam logic [31:0] NtpToUnixAdj = 32'd2085978496;
  localparam logic [31:0] DstShift     = 32'd3600;
  localparam logic signed [12:0] SecsPerHour = 13'sd3600;

  // seconds to days: 86400 = 2^7 * 675
  localparam int          DayLoBits   = 7;
  localparam logic [25:0] Div675Mul   = 26'd50903317;
  localparam int          Div675Shift = 35;
  localparam logic [9:0]  DayHiDiv    = 10'd675;

  // days since 1970-01-01 to days since 1968-03-01
  localparam logic [15:0] MarchBase = 16'd671;
  // day count of 2100-03-01, after the missing leap day
  localparam logic [15:0] Mar2100   = 16'd48212;
  localparam logic [10:0] QuadDays  = 11'd1461;
  localparam logic [15:0] Div1461Mul   = 16'd45934;
  localparam int          Div1461Shift = 26;
  localparam logic [5:0]  Quad2100     = 6'd33;
  localparam logic [10:0] YearDays     = 11'd365;
  localparam logic [11:0] BaseYear     = 12'd1968;

  localparam logic [17:0] Div60Mul   = 18'd139811;
  localparam int          Div60Shift = 23;
  localparam logic [16:0] Div60      = 17'd60;

  localparam logic [16:0] Div7Mul    = 17'd74899;
  localparam int          Div7Shift  = 19;
  localparam logic [15:0] Div7       = 16'd7;
  // 1970-01-01 was a thursday
  localparam logic [15:0] ThursdayAdj = 16'd4;

  localparam logic [3:0] MonthMar = 4'd3;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthOct = 4'd10;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [8:0]  yday;
  } cal_t;

  // first day of each month in a march-based year
  function automatic logic [8:0] month_start(input logic [3:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/ntpcal_decode.sv -----
// ----------------------------------------------------------------------------
// ntpcal_decode
// Six-stage decode of a unix second count into date, time and weekday.
// ----------------------------------------------------------------------------
module ntpcal_decode (
  input  logic                      clk,
  input  logic [5:0]                en,
  input  logic [31:0]               t,
  output ntpcal_pkg::cal_t          cal
);
  import ntpcal_pkg::*;

  // stage 1
  logic [50:0] day_prod;
  logic [15:0] s1_days;
  logic [24:0] s1_hi;
  logic [6:0]  s1_lo;

  // stage 2
  logic [24:0] day_rem;
  logic [15:0] s2_days;
  logic [16:0] s2_rs;

  // stage 3
  logic [15:0] e_raw;
  logic [15:0] e_adj;
  logic [15:0] wd_in;
  logic [31:0] quad_prod;
  logic [34:0] min_prod;
  logic [32:0] wd_prod;
  logic [15:0] s3_e;
  logic [5:0]  s3_quad;
  logic [10:0] s3_m;
  logic [16:0] s3_rs;
  logic [15:0] s3_wd_in;
  logic [13:0] s3_wd_q;

  // stage 4
  logic [15:0] quad_rem;
  logic [16:0] sec_full;
  logic [28:0] hour_prod;
  logic [15:0] wd_full;
  logic [10:0] s4_r;
  logic [5:0]  s4_quad;
  logic [10:0] s4_m;
  logic [4:0]  s4_hour;
  logic [5:0]  s4_sec;
  logic [2:0]  s4_wd;

  // stage 5
  logic [1:0]  ry;
  logic [10:0] rd_full;
  logic [10:0] min_full;
  logic [8:0]  s5_rd;
  logic [11:0] s5_yr;
  logic        s5_leap;
  logic [5:0]  s5_min;
  logic [4:0]  s5_hour;
  logic [5:0]  s5_sec;
  logic [2:0]  s5_wd;

  // stage 6
  logic [3:0]  mi;
  logic [8:0]  mstart;
  logic [8:0]  day_full;
  logic [8:0]  yd_raw;
  logic [8:0]  yd_lim;
  logic        wrap;

  assign day_prod = 51'(t[31:DayLoBits]) * 51'(Div675Mul);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_days <= day_prod[Div675Shift +: 16];
      s1_hi   <= t[31:DayLoBits];
      s1_lo   <= t[DayLoBits-1:0];
    end
  end

  assign day_rem = s1_hi - 25'(s1_days) * 25'(DayHiDiv);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_days <= s1_days;
      s2_rs   <= {day_rem[9:0], s1_lo};
    end
  end

  always_comb begin
    e_raw     = s2_days + MarchBase;
    // no feb 29 in 2100
    e_adj     = e_raw + 16'(e_raw >= Mar2100);
    quad_prod = 32'(e_adj) * 32'(Div1461Mul);
    min_prod  = 35'(s2_rs) * 35'(Div60Mul);
    wd_in     = s2_days + ThursdayAdj;
    wd_prod   = 33'(wd_in) * 33'(Div7Mul);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_e     <= e_adj;
      s3_quad  <= quad_prod[Div1461Shift +: 6];
      s3_m     <= min_prod[Div60Shift +: 11];
      s3_rs    <= s2_rs;
      s3_wd_in <= wd_in;
      s3_wd_q  <= wd_prod[Div7Shift +: 14];
    end
  end

  always_comb begin
    quad_rem  = s3_e - 16'(s3_quad) * 16'(QuadDays);
    sec_full  = s3_rs - 17'(s3_m) * Div60;
    hour_prod = 29'(s3_m) * 29'(Div60Mul);
    wd_full   = s3_wd_in - 16'(s3_wd_q) * Div7;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_r    <= quad_rem[10:0];
      s4_quad <= s3_quad;
      s4_m    <= s3_m;
      s4_hour <= hour_prod[Div60Shift +: 5];
      s4_sec  <= sec_full[5:0];
      s4_wd   <= wd_full[2:0];
    end
  end

  always_comb begin
    if (s4_r >= 3 * YearDays) begin
      ry = 2'd3;
    end else if (s4_r >= 2 * YearDays) begin
      ry = 2'd2;
    end else if (s4_r >= YearDays) begin
      ry = 2'd1;
    end else begin
      ry = 2'd0;
    end
    rd_full  = s4_r - 11'(ry) * YearDays;
    min_full = s4_m - 11'(s4_hour) * 11'(Div60);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_rd   <= rd_full[8:0];
      s5_yr   <= BaseYear + {4'd0, s4_quad, 2'b00} + 12'(ry);
      s5_leap <= (ry == 2'd0) && (s4_quad != Quad2100);
      s5_min  <= min_full[5:0];
      s5_hour <= s4_hour;
      s5_sec  <= s4_sec;
      s5_wd   <= s4_wd;
    end
  end

  always_comb begin
    mi = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (month_start(4'(k)) <= s5_rd) begin
        mi = mi + 4'd1;
      end
    end
    mstart   = month_start(mi);
    day_full = s5_rd - mstart + 9'd1;
    wrap     = (mi >= 4'd10);
    yd_raw   = s5_rd + 9'd59 + 9'(s5_leap);
    yd_lim   = 9'd365 + 9'(s5_leap);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      cal.year    <= s5_yr + 12'(wrap);
      cal.month   <= wrap ? mi - 4'd9 : mi + 4'd3;
      cal.day     <= day_full[4:0];
      cal.hour    <= s5_hour;
      cal.minute  <= s5_min;
      cal.second  <= s5_sec;
      cal.weekday <= s5_wd;
      cal.yday    <= (yd_raw >= yd_lim) ? yd_raw - yd_lim : yd_raw;
    end
  end

endmodule

// ----- sv/ntpcal_dst.sv -----
// ----------------------------------------------------------------------------
// ntpcal_dst
// European summer time rule on the standard decode and output register.
// ----------------------------------------------------------------------------
module ntpcal_dst (
  input  logic             clk,
  input  logic             en,
  input  logic             dst_enable,
  input  ntpcal_pkg::cal_t cal_std,
  input  ntpcal_pkg::cal_t cal_dst,
  output ntpcal_pkg::cal_t cal,
  output logic             dst_active
);
  import ntpcal_pkg::*;

  logic [5:0]  dow_raw;
  logic [11:0] dow_prod;
  logic [5:0]  dow31;
  logic [4:0]  last_sun;
  logic        summer;

  always_comb begin
    // weekday of the 31st, then the last sunday on or before it
    dow_raw  = 6'(cal_std.weekday) + 6'd31 - 6'(cal_std.day);
    dow_prod = 12'(dow_raw) * 12'd37;
    dow31    = dow_raw - 6'(dow_prod[11:8]) * 6'd7;
    last_sun = 5'd31 - dow31[4:0];
    summer   = 1'b0;
    if (cal_std.month >= MonthApr && cal_std.month <= MonthSep) begin
      summer = 1'b1;
    end else if (cal_std.month == MonthMar) begin
      summer = (cal_std.day > last_sun) ||
               (cal_std.day == last_sun && cal_std.hour >= 5'd2);
    end else if (cal_std.month == MonthOct) begin
      summer = (cal_std.day < last_sun) ||
               (cal_std.day == last_sun && cal_std.hour < 5'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dst_enable && summer) begin
        cal        <= cal_dst;
        dst_active <= 1'b1;
      end else begin
        cal        <= cal_std;
        dst_active <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/ntp_time_to_local_calendar.sv -----
// ----------------------------------------------------------------------------
// ntp_time_to_local_calendar
// NTP seconds to local calendar date and time with optional EU summer time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  ts        in         ts_valid / ts_ready    ntp_seconds
//  cal       out        cal_valid / cal_ready  year .. day_of_year, dst_active
//  cfg       in         cfg_wr_en              cfg_index, cfg_wr_data
//
//  one request per cycle while the output is not stalled; a stalled output holds the flow
//  the pipeline is the offset stage, six decode stages and the summer time stage
//  reset clears the stage valid bits, offset to zero and summer time off
//  each stage moves on when it is empty or the next one moves; a stalled
//  output keeps accepting until the bubbles ahead of it are filled
// ----------------------------------------------------------------------------
module ntp_time_to_local_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_wr_data,
  input  logic        ts_valid,
  output logic        ts_ready,
  input  logic [31:0] ntp_seconds,
  output logic        cal_valid,
  input  logic        cal_ready,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [2:0]  weekday,
  output logic [8:0]  day_of_year,
  output logic        dst_active
);
  import ntpcal_pkg::*;

  logic [PipeStages-1:0] vld;
  logic [PipeStages-1:0] go;

  logic [31:0]        adj_std;
  logic [31:0]        adj_dst;
  logic               dst_enable;
  logic signed [4:0]  off_hours;
  logic signed [17:0] off_secs;
  logic [31:0]        off_ext;

  logic [31:0] t_std;
  logic [31:0] t_dst;
  cal_t        cal_std;
  cal_t        cal_dst;
  cal_t        cal;

  // configuration
  always_comb begin
    off_hours = cfg_wr_data;
    off_secs  = off_hours * SecsPerHour;
    off_ext   = 32'(off_secs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_std    <= NtpToUnixAdj;
      adj_dst    <= NtpToUnixAdj + DstShift;
      dst_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CfgUtcOffset: begin
          adj_std <= NtpToUnixAdj + off_ext;
          adj_dst <= NtpToUnixAdj + DstShift + off_ext;
        end
        CfgDstEnable: begin
          dst_enable <= cfg_wr_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  always_comb begin
    go[PipeStages-1] = !vld[PipeStages-1] || cal_ready;
    for (int k = PipeStages - 2; k >= 0; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) begin
        vld[0] <= ts_valid;
      end
      for (int k = 1; k < PipeStages; k++) begin
        if (go[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign ts_ready  = go[0];
  assign cal_valid = vld[PipeStages-1];

  // offset stage: standard and summer time second counts
  always_ff @(posedge clk) begin
    if (go[0]) begin
      t_std <= ntp_seconds + adj_std;
      t_dst <= ntp_seconds + adj_dst;
    end
  end

  ntpcal_decode u_dec_std (
    .clk (clk),
    .en  (go[LaneStages:1]),
    .t   (t_std),
    .cal (cal_std)
  );

  ntpcal_decode u_dec_dst (
    .clk (clk),
    .en  (go[LaneStages:1]),
    .t   (t_dst),
    .cal (cal_dst)
  );

  ntpcal_dst u_dst (
    .clk        (clk),
    .en         (go[PipeStages-1]),
    .dst_enable (dst_enable),
    .cal_std    (cal_std),
    .cal_dst    (cal_dst),
    .cal        (cal),
    .dst_active (dst_active)
  );

  assign year        = cal.year;
  assign month       = cal.month;
  assign day         = cal.day;
  assign hour        = cal.hour;
  assign minute      = cal.minute;
  assign second      = cal.second;
  assign weekday     = cal.weekday;
  assign day_of_year = cal.yday;

  // checks
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !ts_ready |-> (cal_valid && !cal_ready))
    else $error("request refused without output stall");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 &&
                   hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 &&
                   weekday <= 3'd6 && day_of_year <= 9'd365))
    else $error("calendar field out of range");

  a_dst_months: assert property (@(posedge clk) disable iff (rst)
    (cal_valid && dst_active) |-> (month >= MonthMar && month <= MonthOct))
    else $error("summer time flagged outside march to october");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NTP timestamp to local calendar converter.
// Timestamps are driven through the valid/ready input. Each accepted timestamp
// is converted in the bench to local date, time, weekday, day of year and
// summer time flag, and the result is compared with what the block delivers.
// The run covers several zone offsets, including the 5-bit extremes, with
// summer time on and off. The random timestamps cluster around summer time
// switch-overs, month and year ends, and the wrap of the 32-bit count. The
// input and output sides idle at random, and a long stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
  import ntpcal_pkg::*;

  localparam int LongStall = 64;

  // march-based month lengths, index 0 is march
  localparam logic [11:0][4:0] MarchLen = {5'd29, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30,
                                           5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  // 2000-03-01 00:00:00 in unix seconds
  localparam longint Mar2000 = 64'd951868800;
  localparam longint NtpEpochGap = 64'd2208988800;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic        dst_active;
  } local_time_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_index = CfgUtcOffset;
  logic [4:0]  cfg_wr_data = 5'd0;
  logic        ts_valid = 1'b0;
  logic        ts_ready;
  logic [31:0] ntp_seconds = 32'd0;
  logic        cal_valid;
  logic        cal_ready = 1'b0;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;
  logic [8:0]  day_of_year;
  logic        dst_active;

  // bench copy of the registers
  logic signed [4:0] tz_hours = 5'sd0;
  logic              dst_on = 1'b0;

  logic [31:0] ntp_backlog[$];
  local_time_t local_time_q[$];
  logic        req_taken = 1'b0;
  int          send_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          stall_asked = 0;
  int          stall_served = 0;
  int          stall_left = 0;
  int          mismatch_count = 0;
  int          accepted_count = 0;
  int          summer_count = 0;
  int          setting_count = 0;

  ntp_time_to_local_calendar u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .ts_valid    (ts_valid),
    .ts_ready    (ts_ready),
    .ntp_seconds (ntp_seconds),
    .cal_valid   (cal_valid),
    .cal_ready   (cal_ready),
    .year        (year),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .weekday     (weekday),
    .day_of_year (day_of_year),
    .dst_active  (dst_active)
  );

  always #5 clk = ~clk;

  function automatic local_time_t split_seconds(input logic [31:0] t);
    longint secs, days, rs, wd, qc, rd, cc, qq, ry, yd, yr, leap;
    int mi;
    local_time_t c;
    secs = $signed({32'b0, t}) - Mar2000;
    days = secs / 86400;
    rs = secs % 86400;
    if (rs < 0) begin
      rs += 86400;
      days--;
    end
    wd = (3 + days) % 7;
    if (wd < 0) wd += 7;
    qc = days / 146097;
    rd = days % 146097;
    if (rd < 0) begin
      rd += 146097;
      qc--;
    end
    cc = rd / 36524;
    if (cc == 4) cc--;
    rd -= cc * 36524;
    qq = rd / 1461;
    if (qq == 25) qq--;
    rd -= qq * 1461;
    ry = rd / 365;
    if (ry == 4) ry--;
    rd -= ry * 365;
    leap = (ry == 0 && (qq != 0 || cc == 0)) ? 1 : 0;
    yd = rd + 59 + leap;
    if (yd >= 365 + leap) yd -= 365 + leap;
    yr = ry + 4 * qq + 100 * cc + 400 * qc + 2000;
    for (mi = 0; mi < 11 && longint'(MarchLen[mi]) <= rd; mi++) rd -= MarchLen[mi];
    mi += 3;
    if (mi > 12) begin
      mi -= 12;
      yr++;
    end
    c.year = yr[11:0];
    c.month = mi[3:0];
    c.day = 5'(rd + 1);
    c.hour = 5'(rs / 3600);
    c.minute = 6'((rs / 60) % 60);
    c.second = 6'(rs % 60);
    c.weekday = wd[2:0];
    c.day_of_year = yd[8:0];
    c.dst_active = 1'b0;
    return c;
  endfunction

  function automatic bit summer_time_on(input local_time_t c);
    int last_sun;
    last_sun = 31 - ((int'(c.weekday) + 31 - int'(c.day)) % 7);
    if (c.month > 3 && c.month < 10) return 1'b1;
    if (c.month == 3 && (c.day > last_sun || (c.day == last_sun && c.hour >= 2))) return 1'b1;
    if (c.month == 10 && (c.day < last_sun || (c.day == last_sun && c.hour < 3))) return 1'b1;
    return 1'b0;
  endfunction

  function automatic local_time_t predict_local(input logic [31:0] ntp,
                                                input logic signed [4:0] zone,
                                                input logic summer_en);
    logic [31:0] t;
    local_time_t c;
    t = ntp - 32'd2208988800 + 32'(int'(zone) * 3600);
    c = split_seconds(t);
    if (summer_en && summer_time_on(c)) begin
      c = split_seconds(t + 32'd3600);
      c.dst_active = 1'b1;
    end
    return c;
  endfunction

  // days since 1970-01-01; day 0 or past month end rolls over linearly
  function automatic longint civil_days(input int y, input int m, input int d);
    int era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = y / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return longint'(era) * 146097 + doe - 719468;
  endfunction

  function automatic int last_sunday(input int y, input int m);
    return 31 - int'((civil_days(y, m, 31) + 4) % 7);
  endfunction

  // ntp seconds of a local standard time in the given zone
  function automatic logic [31:0] to_ntp(input int y, input int m, input int d, input int hh,
                                         input int mi, input int ss, input int zone);
    longint s;
    s = civil_days(y, m, d) * 86400 + hh * 3600 + mi * 60 + ss - zone * 3600 + NtpEpochGap;
    return s[31:0];
  endfunction

  function automatic logic [31:0] pick_ntp(input int zone);
    int kind, yr, mon, dd;
    logic [31:0] base;
    kind = $urandom_range(99);
    yr = $urandom_range(2105, 1970);
    if (kind < 40) return $urandom;
    if (kind < 75) begin
      mon = $urandom_range(1) ? 3 : 10;
      dd = last_sunday(yr, mon);
      if ($urandom_range(3) == 0) dd = dd + int'($urandom_range(2)) - 1;
      return to_ntp(yr, mon, dd, $urandom_range(4), $urandom_range(59), $urandom_range(59),
                    zone);
    end
    if (kind < 90)
      return to_ntp(yr, $urandom_range(12, 1), $urandom_range(1), $urandom_range(1) ? 23 : 0,
                    $urandom_range(59), $urandom_range(59), zone);
    case ($urandom_range(2))
      0:       base = 32'd0;
      1:       base = 32'd2208988800 - 32'(zone * 3600);
      default: base = 32'd2208988799 - 32'(zone * 3600);
    endcase
    return base + $urandom_range(14400) - 32'd7200;
  endfunction

  // request side
  always @(negedge clk) begin
    if (rst) begin
      ts_valid <= 1'b0;
    end else if (!ts_valid || req_taken) begin
      if (ntp_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        ts_valid <= 1'b1;
        ntp_seconds <= ntp_backlog.pop_front();
      end else begin
        ts_valid <= 1'b0;
      end
    end
  end

  // result side, with the long stall counted here
  always @(negedge clk) begin
    if (rst) begin
      cal_ready <= 1'b0;
    end else if (stall_left != 0) begin
      cal_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_asked) begin
      stall_served <= stall_asked;
      stall_left <= LongStall;
      cal_ready <= 1'b0;
    end else begin
      cal_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    local_time_t want, got;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= ts_valid && ts_ready;
      if (ts_valid && ts_ready) begin
        local_time_q.push_back(predict_local(ntp_seconds, tz_hours, dst_on));
        accepted_count++;
      end
      if (cal_valid && cal_ready) begin
        got = {year, month, day, hour, minute, second, weekday, day_of_year, dst_active};
        if (got.dst_active === 1'b1) summer_count++;
        if (local_time_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count++;
        end else begin
          want = local_time_q.pop_front();
          compare_field("year", want.year, got.year);
          compare_field("month", want.month, got.month);
          compare_field("day", want.day, got.day);
          compare_field("hour", want.hour, got.hour);
          compare_field("minute", want.minute, got.minute);
          compare_field("second", want.second, got.second);
          compare_field("weekday", want.weekday, got.weekday);
          compare_field("day_of_year", want.day_of_year, got.day_of_year);
          compare_field("dst_active", want.dst_active, got.dst_active);
        end
      end
    end
  end

  task automatic wait_drained();
    while (ntp_backlog.size() != 0 || ts_valid || local_time_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    if (idx == CfgUtcOffset) tz_hours = val;
    else dst_on = val[0];
    @(negedge clk);
  endtask

  task automatic apply_setting(input int zone, input bit summer_en);
    wait_drained();
    write_reg(CfgUtcOffset, 5'(zone));
    write_reg(CfgDstEnable, {4'b0, summer_en});
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  task automatic run_setting(input int zone, input bit summer_en, input int count);
    apply_setting(zone, summer_en);
    repeat (count) ntp_backlog.push_back(pick_ntp(zone));
  endtask

  initial begin
    int oct_sun, mar_sun;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 28;
    rcv_idle_pct = 79;

    // wrap ends, calendar edges, leap and non-leap centuries
    apply_setting(0, 1'b0);
    ntp_backlog.push_back(32'd0);
    ntp_backlog.push_back(32'hFFFF_FFFF);
    ntp_backlog.push_back(32'd2208988800);
    ntp_backlog.push_back(32'd2208988799);
    ntp_backlog.push_back(to_ntp(2023, 12, 31, 23, 59, 59, 0));
    ntp_backlog.push_back(to_ntp(2024, 1, 1, 0, 0, 0, 0));
    ntp_backlog.push_back(to_ntp(2000, 2, 29, 12, 0, 0, 0));
    ntp_backlog.push_back(to_ntp(2100, 2, 28, 23, 59, 59, 0));
    ntp_backlog.push_back(to_ntp(2100, 3, 1, 0, 0, 0, 0));
    ntp_backlog.push_back(to_ntp(2024, 12, 31, 12, 0, 0, 0));

    // summer time switch-overs
    apply_setting(1, 1'b1);
    mar_sun = last_sunday(2024, 3);
    oct_sun = last_sunday(2024, 10);
    ntp_backlog.push_back(to_ntp(2024, 3, mar_sun - 1, 23, 59, 59, 1));
    ntp_backlog.push_back(to_ntp(2024, 3, mar_sun, 1, 59, 59, 1));
    ntp_backlog.push_back(to_ntp(2024, 3, mar_sun, 2, 0, 0, 1));
    ntp_backlog.push_back(to_ntp(2018, 3, last_sunday(2018, 3), 2, 0, 0, 1));
    ntp_backlog.push_back(to_ntp(2018, 3, last_sunday(2018, 3) + 1, 0, 0, 0, 1));
    ntp_backlog.push_back(to_ntp(2024, 10, oct_sun - 1, 12, 0, 0, 1));
    ntp_backlog.push_back(to_ntp(2024, 10, oct_sun, 2, 59, 59, 1));
    ntp_backlog.push_back(to_ntp(2024, 10, oct_sun, 3, 0, 0, 1));
    ntp_backlog.push_back(to_ntp(2024, 10, 31, 12, 0, 0, 1));
    ntp_backlog.push_back(to_ntp(2024, 4, 1, 0, 0, 0, 1));
    ntp_backlog.push_back(to_ntp(2024, 9, 30, 23, 30, 0, 1));
    ntp_backlog.push_back(to_ntp(2024, 11, 1, 0, 0, 0, 1));
    ntp_backlog.push_back(to_ntp(2024, 1, 15, 8, 0, 0, 1));

    // long output stall while requests keep coming
    apply_setting(0, 1'b1);
    stall_asked++;
    repeat (300) ntp_backlog.push_back(pick_ntp(0));
    run_setting(-12, 1'b1, 300);

    wait_drained();
    send_idle_pct = 79;
    rcv_idle_pct = 28;
    run_setting(14, 1'b1, 300);
    run_setting(-16, 1'b0, 150);
    run_setting(15, 1'b1, 150);

    wait_drained();
    send_idle_pct = 0;
    rcv_idle_pct = 0;
    run_setting($signed(5'($urandom_range(31))), 1'b1, 350);
    run_setting($signed(5'($urandom_range(31))), $urandom_range(1), 350);

    wait_drained();
    repeat (PipeStages + 4) @(posedge clk);
    $display("covered %0d timestamps over %0d zone and summer time settings", accepted_count,
             setting_count);
    $display("%0d results carried the summer time hour", summer_count);
    if (mismatch_count == 0 && local_time_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
